@@ hw/rtl/bstl_pkg.sv @@
`default_nettype none

package bstl_pkg;

	localparam int CNT_W      = 24;
	localparam int FIELD_W    = 24;
	localparam int NKW        = 6;
	localparam int KW_MAXLEN  = 7;
	localparam int ILEN_W     = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [ILEN_W-1:0]  ilen_t;
	typedef logic [NKW-1:0]     kw_flags_t;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUM,
		MODE_STR
	} mode_t;

	typedef enum logic [2:0] {
		KIND_KEYWORD = 3'd0,
		KIND_IDENT   = 3'd1,
		KIND_NUMBER  = 3'd2,
		KIND_STRING  = 3'd3,
		KIND_SYMBOL  = 3'd4,
		KIND_EOF     = 3'd5,
		KIND_ERROR   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_NEWLINE,
		CLS_ALPHA,
		CLS_DIGIT,
		CLS_QUOTE,
		CLS_SYMBOL,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  kw;
		field_t      start;
		field_t      len;
		logic [7:0]  ch;
		field_t      line;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} tok_push_t;

	// Keyword text is left-justified, first character in the top byte.
	localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [NKW] = '{
		{"macro", 16'h0000},
		"capsule",
		{"val", 32'h0000_0000},
		{"loop", 24'h00_0000},
		{"say", 32'h0000_0000},
		{"end", 32'h0000_0000}
	};

	localparam logic [2:0] KW_LEN [NKW] = '{3'd5, 3'd7, 3'd3, 3'd4, 3'd3, 3'd3};

	function automatic cnt_t sat_inc(cnt_t v);
		return (&v) ? v : v + cnt_t'(1);
	endfunction

	function automatic cls_t classify(logic [7:0] c);
		cls_t r;
		unique case (c) inside
			8'h20, 8'h09, 8'h0D: r = CLS_SPACE;
			8'h0A: r = CLS_NEWLINE;
			[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: r = CLS_ALPHA;
			[8'h30:8'h39]: r = CLS_DIGIT;
			8'h22: r = CLS_QUOTE;
			8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3A, 8'h2C, 8'h3D, 8'h2B, 8'h2D, 8'h2A,
			8'h2F: r = CLS_SYMBOL;
			default: r = CLS_OTHER;
		endcase
		return r;
	endfunction

	function automatic kw_flags_t kw_feed(kw_flags_t flags, ilen_t k, logic [7:0] c);
		kw_flags_t r;
		logic [7:0] kc;
		r = flags;
		for (int i = 0; i < NKW; i++) begin
			kc = KW_TEXT[i][(KW_MAXLEN-1-int'(k[2:0]))*8 +: 8];
			if (k >= ilen_t'(KW_LEN[i]) || kc != c) begin
				r[i] = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bstl_lexer.sv @@
`default_nettype none

module bstl_lexer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic                cmd,
	input  logic [7:0]          byte_value,
	output bstl_pkg::tok_push_t tok_push
);
	import bstl_pkg::*;

	mode_t     mode_q, mode_n;
	cnt_t      start_q, start_n;
	cnt_t      pos_q, pos_n;
	cnt_t      line_q, line_n;
	kw_flags_t flags_q, flags_n;
	ilen_t     ilen_q, ilen_n;

	logic      accept;
	cls_t      cls;
	cnt_t      span;
	tok_t      pend_tok, tok_a, tok_b;
	logic      a_v, b_v;
	logic      finish, do_start;
	kind_t     id_kind;
	logic [2:0] id_kw;
	kw_flags_t fresh_flags, cont_flags;
	ilen_t     cont_ilen;

	assign accept = push && !full;
	assign cls    = classify(byte_value);
	assign span   = (pos_q >= start_q) ? pos_q - start_q : '0;

	assign fresh_flags = kw_feed('1, '0, byte_value);
	assign cont_flags  = kw_feed(flags_q, ilen_q, byte_value);
	assign cont_ilen   = (&ilen_q) ? ilen_q : ilen_q + ilen_t'(1);

	always_comb begin
		id_kind = KIND_IDENT;
		id_kw   = 3'd0;
		for (int i = NKW - 1; i >= 0; i--) begin
			if (flags_q[i] && ilen_q == ilen_t'(KW_LEN[i])) begin
				id_kind = KIND_KEYWORD;
				id_kw   = 3'(i);
			end
		end
	end

	always_comb begin
		pend_tok       = '0;
		pend_tok.start = field_t'(start_q);
		pend_tok.len   = field_t'(span);
		pend_tok.line  = field_t'(line_q);
		unique case (mode_q)
			MODE_IDENT: begin
				pend_tok.kind = id_kind;
				pend_tok.kw   = id_kw;
			end
			MODE_NUM:  pend_tok.kind = KIND_NUMBER;
			MODE_STR:  pend_tok.kind = KIND_STRING;
			MODE_IDLE: pend_tok.kind = KIND_IDENT;
			default:   pend_tok.kind = KIND_IDENT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			pos_q   <= '0;
			line_q  <= cnt_t'(1);
			flags_q <= '1;
			ilen_q  <= '0;
		end else begin
			mode_q  <= mode_n;
			start_q <= start_n;
			pos_q   <= pos_n;
			line_q  <= line_n;
			flags_q <= flags_n;
			ilen_q  <= ilen_n;
		end
	end

	always_comb begin
		mode_n   = mode_q;
		start_n  = start_q;
		pos_n    = pos_q;
		line_n   = line_q;
		flags_n  = flags_q;
		ilen_n   = ilen_q;
		a_v      = 1'b0;
		b_v      = 1'b0;
		finish   = 1'b0;
		do_start = 1'b0;
		tok_a    = pend_tok;
		tok_b    = '0;
		tok_b.line  = field_t'(line_q);
		tok_b.start = field_t'(pos_q);

		if (accept) begin
			if (cmd == CMD_END) begin
				a_v        = (mode_q != MODE_IDLE);
				b_v        = 1'b1;
				tok_b.kind = KIND_EOF;
				mode_n     = MODE_IDLE;
				start_n    = '0;
				pos_n      = '0;
				line_n     = cnt_t'(1);
				flags_n    = '1;
				ilen_n     = '0;
			end else begin
				unique case (mode_q)
					MODE_IDENT: begin
						if (cls == CLS_ALPHA || cls == CLS_DIGIT) begin
							flags_n = cont_flags;
							ilen_n  = cont_ilen;
						end else begin
							finish   = 1'b1;
							do_start = 1'b1;
						end
					end
					MODE_NUM: begin
						if (cls != CLS_DIGIT) begin
							finish   = 1'b1;
							do_start = 1'b1;
						end
					end
					MODE_STR: begin
						if (cls == CLS_QUOTE) begin
							finish = 1'b1;
						end else if (cls == CLS_NEWLINE) begin
							line_n = sat_inc(line_q);
						end
					end
					MODE_IDLE: do_start = 1'b1;
					default: do_start = 1'b1;
				endcase

				if (finish) begin
					a_v    = 1'b1;
					mode_n = MODE_IDLE;
				end

				if (do_start) begin
					case (cls)
						CLS_NEWLINE: line_n = sat_inc(line_q);
						CLS_ALPHA: begin
							mode_n  = MODE_IDENT;
							start_n = pos_q;
							flags_n = fresh_flags;
							ilen_n  = ilen_t'(1);
						end
						CLS_DIGIT: begin
							mode_n  = MODE_NUM;
							start_n = pos_q;
						end
						CLS_QUOTE: begin
							mode_n  = MODE_STR;
							start_n = sat_inc(pos_q);
						end
						CLS_SYMBOL: begin
							b_v        = 1'b1;
							tok_b.kind = KIND_SYMBOL;
							tok_b.len  = field_t'(1);
							tok_b.ch   = byte_value;
						end
						CLS_OTHER: begin
							b_v        = 1'b1;
							tok_b.kind = KIND_ERROR;
							tok_b.len  = field_t'(1);
							tok_b.ch   = byte_value;
						end
						default: ;
					endcase
				end

				pos_n = sat_inc(pos_q);
			end
		end

		tok_a.last  = !b_v;
		tok_b.last  = 1'b1;
		tok_push.n  = {1'b0, a_v} + {1'b0, b_v};
		tok_push.t0 = a_v ? tok_a : tok_b;
		tok_push.t1 = tok_b;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_END |=> mode_q == MODE_IDLE && pos_q == '0 && line_q == cnt_t'(1))
		else $error("State not restored after end of source.");

	assert property (@(posedge clk) disable iff (!arst_n) line_q != '0)
		else $error("Line counter reached zero.");

	assert property (@(posedge clk) disable iff (!arst_n)
		tok_push.n == 2'd2 |-> !tok_push.t0.last && tok_push.t1.last)
		else $error("Two-token beat marks the wrong token as last.");

	assert property (@(posedge clk) disable iff (!arst_n) !accept |-> tok_push.n == 2'd0)
		else $error("Tokens produced without an accepted beat.");

endmodule

`default_nettype wire

@@ hw/rtl/bstl_tok_fifo.sv @@
`default_nettype none

module bstl_tok_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  bstl_pkg::tok_push_t tok_push,
	input  logic                pop,
	output logic                full,
	output logic                empty,
	output bstl_pkg::tok_t      head
);
	import bstl_pkg::*;

	tok_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q, rd_q;
	logic [FIFO_AW:0]     cnt_q;
	logic                 pop_ok;
	logic [FIFO_AW-1:0]   wr_next;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q > (FIFO_AW+1)'(FIFO_DEPTH - 2));
	assign pop_ok  = pop && !empty;
	assign head    = mem_q[rd_q];
	assign wr_next = wr_q + FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (tok_push.n != 2'd0) begin
			mem_q[wr_q] <= tok_push.t0;
		end
		if (tok_push.n == 2'd2) begin
			mem_q[wr_next] <= tok_push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_AW'(tok_push.n);
			if (pop_ok) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(tok_push.n) - (FIFO_AW+1)'(pop_ok);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("Token queue overflow.");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop_ok && tok_push.n == 2'd0 && cnt_q == (FIFO_AW+1)'(1) |=> empty)
		else $error("Queue not empty after its last token was taken.");

	assert property (@(posedge clk) disable iff (!arst_n)
		tok_push.n != 2'd0 |=> !empty)
		else $error("Queue empty after a token was written.");

endmodule

`default_nettype wire

@@ hw/rtl/byte_stream_token_lexer.sv @@
// Streaming lexer: source bytes in, token descriptors out.
// Input queue port: drive cmd and byte_value with push; a beat is taken on a
// clock edge where push is high and full is low. cmd low carries one source
// byte, cmd high marks the end of the source.
// Output queue port: while empty is low the oldest token is on the result
// ports; it is taken on a clock edge where pop is high. Each token gives its
// kind, keyword index, start offset, length, character and line, and
// last_of_run marks the final token caused by one input beat.
// A token is written into the token queue on the clock edge that takes the
// beat completing it. Throughput: one input beat per cycle as long as the
// reader keeps up; a beat may complete up to two tokens (a token ended by a
// symbol or a stray byte, or a pending token plus the end token), and the
// reader drains one token per cycle, so the reader sets that rate, with the
// four-entry token queue buffering between the lexer and the output side.
// full rises when fewer than two queue entries are free, so a stalled reader
// holds the writer back without losing tokens.
// Reset: the queue is empty, the position counter is zero and the line counter
// is one. An end-of-source beat restores the same counter state after its tokens.
`default_nettype none

module byte_stream_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [7:0]  byte_value,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  token_kind,
	output logic [2:0]  keyword_index,
	output logic [23:0] start_offset,
	output logic [23:0] lexeme_length,
	output logic [7:0]  char_value,
	output logic [23:0] token_line,
	output logic        last_of_run
);
	import bstl_pkg::*;

	tok_push_t tok_push;
	tok_t      head;

	bstl_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.byte_value (byte_value),
		.tok_push   (tok_push)
	);

	bstl_tok_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_push (tok_push),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	assign token_kind    = head.kind;
	assign keyword_index = head.kw;
	assign start_offset  = 24'(head.start);
	assign lexeme_length = 24'(head.len);
	assign char_value    = head.ch;
	assign token_line    = 24'(head.line);
	assign last_of_run   = head.last;

endmodule

`default_nettype wire

@@ dv/byte_stream_token_lexer_tb.sv @@
`timescale 1ns / 100ps

module byte_stream_token_lexer_tb;

	import bstl_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        cmd = CMD_BYTE;
	logic [7:0]  byte_value = 8'd0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [2:0]  token_kind;
	logic [2:0]  keyword_index;
	logic [23:0] start_offset;
	logic [23:0] lexeme_length;
	logic [7:0]  char_value;
	logic [23:0] token_line;
	logic        last_of_run;

	byte_stream_token_lexer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.byte_value    (byte_value),
		.empty         (empty),
		.pop           (pop),
		.token_kind    (token_kind),
		.keyword_index (keyword_index),
		.start_offset  (start_offset),
		.lexeme_length (lexeme_length),
		.char_value    (char_value),
		.token_line    (token_line),
		.last_of_run   (last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	string kw_names [6] = '{"macro", "capsule", "val", "loop", "say", "end"};

	// Lexer state as predicted from the accepted source beats.
	mode_t     scan;
	cnt_t      tok_start;
	cnt_t      pos;
	cnt_t      line_no;
	kw_flags_t kw_live;
	ilen_t     id_len;

	tok_t expected_tokens [$];
	tok_t beat_tokens [$];
	tok_t want;

	int errors = 0;
	int beats_sent = 0;
	int sources_ended = 0;
	int tokens_seen = 0;
	int kind_tally [8];
	int idle_cycles = 0;
	int stall_left = 0;
	bit steady = 1'b0;

	function automatic cls_t classify_byte(logic [7:0] c);
		if (c == " " || c == "\t" || c == 8'h0D)
			return CLS_SPACE;
		if (c == "\n")
			return CLS_NEWLINE;
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_")
			return CLS_ALPHA;
		if (c >= "0" && c <= "9")
			return CLS_DIGIT;
		if (c == "\"")
			return CLS_QUOTE;
		if (c == "(" || c == ")" || c == "{" || c == "}" || c == ":" || c == "," ||
				c == "=" || c == "+" || c == "-" || c == "*" || c == "/")
			return CLS_SYMBOL;
		return CLS_OTHER;
	endfunction

	function automatic cnt_t bump(cnt_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void clear_lexer();
		scan = MODE_IDLE;
		tok_start = '0;
		pos = '0;
		line_no = cnt_t'(1);
		kw_live = '1;
		id_len = '0;
	endfunction

	function automatic void add_token(kind_t k, logic [2:0] kw, cnt_t st, cnt_t ln,
			logic [7:0] ch);
		tok_t t;
		t.kind = k;
		t.kw = kw;
		t.start = field_t'(st);
		t.len = field_t'(ln);
		t.ch = ch;
		t.line = field_t'(line_no);
		t.last = 1'b0;
		beat_tokens.insert(beat_tokens.size(), t);
	endfunction

	function automatic void grow_ident(logic [7:0] c);
		for (int i = 0; i < 6; i++) begin
			if (int'(id_len) >= kw_names[i].len() || kw_names[i][int'(id_len)] != c)
				kw_live[i] = 1'b0;
		end
		if (id_len != 4'hF)
			id_len = id_len + 1'b1;
	endfunction

	function automatic void close_token();
		cnt_t ln;
		kind_t k;
		logic [2:0] kw;
		ln = (pos >= tok_start) ? pos - tok_start : '0;
		k = KIND_IDENT;
		kw = 3'd0;
		case (scan)
			MODE_IDENT: begin
				for (int i = 5; i >= 0; i--) begin
					if (kw_live[i] && int'(id_len) == kw_names[i].len()) begin
						k = KIND_KEYWORD;
						kw = 3'(i);
					end
				end
				add_token(k, kw, tok_start, ln, 8'd0);
			end
			MODE_NUM: add_token(KIND_NUMBER, 3'd0, tok_start, ln, 8'd0);
			MODE_STR: add_token(KIND_STRING, 3'd0, tok_start, ln, 8'd0);
			default: ;
		endcase
		scan = MODE_IDLE;
	endfunction

	function automatic void open_token(logic [7:0] c);
		case (classify_byte(c))
			CLS_SPACE: ;
			CLS_NEWLINE: line_no = bump(line_no);
			CLS_ALPHA: begin
				scan = MODE_IDENT;
				tok_start = pos;
				kw_live = '1;
				id_len = '0;
				grow_ident(c);
			end
			CLS_DIGIT: begin
				scan = MODE_NUM;
				tok_start = pos;
			end
			CLS_QUOTE: begin
				scan = MODE_STR;
				tok_start = bump(pos);
			end
			CLS_SYMBOL: add_token(KIND_SYMBOL, 3'd0, pos, cnt_t'(1), c);
			default: add_token(KIND_ERROR, 3'd0, pos, cnt_t'(1), c);
		endcase
	endfunction

	function automatic void predict_beat(logic c_cmd, logic [7:0] b);
		cls_t cl;
		cl = classify_byte(b);
		beat_tokens.delete();
		if (c_cmd == CMD_END) begin
			close_token();
			add_token(KIND_EOF, 3'd0, pos, '0, 8'd0);
			clear_lexer();
		end else begin
			case (scan)
				MODE_IDENT: begin
					if (cl == CLS_ALPHA || cl == CLS_DIGIT) begin
						grow_ident(b);
					end else begin
						close_token();
						open_token(b);
					end
				end
				MODE_NUM: begin
					if (cl != CLS_DIGIT) begin
						close_token();
						open_token(b);
					end
				end
				MODE_STR: begin
					if (cl == CLS_QUOTE)
						close_token();
					else if (cl == CLS_NEWLINE)
						line_no = bump(line_no);
				end
				default: open_token(b);
			endcase
			pos = bump(pos);
		end
		if (beat_tokens.size() > 0)
			beat_tokens[beat_tokens.size() - 1].last = 1'b1;
		foreach (beat_tokens[i])
			expected_tokens.insert(expected_tokens.size(), beat_tokens[i]);
	endfunction

	function automatic int unsigned pause_len();
		if (steady)
			return 0;
		if ($urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_beat(input logic c_cmd, input logic [7:0] b);
		int unsigned gap;
		gap = pause_len();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= c_cmd;
		byte_value <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_beat(c_cmd, b);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(CMD_BYTE, s[i]);
	endtask

	task automatic send_end();
		send_beat(CMD_END, 8'($urandom_range(0, 255)));
		sources_ended++;
	endtask

	function automatic logic [7:0] random_alpha();
		int unsigned r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		return "_";
	endfunction

	function automatic logic [7:0] random_word_char();
		if ($urandom_range(0, 3) == 0)
			return 8'("0" + $urandom_range(0, 9));
		return random_alpha();
	endfunction

	task automatic send_random_lexeme();
		int unsigned pick;
		int unsigned n;
		string w;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			send_text(kw_names[$urandom_range(0, 5)]);
		end else if (pick < 28) begin
			w = kw_names[$urandom_range(0, 5)];
			case ($urandom_range(0, 2))
				0: w = w.substr(0, w.len() - 2);
				1: w = {w, string'(random_word_char())};
				default: w = w.toupper();
			endcase
			send_text(w);
		end else if (pick < 45) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
			send_beat(CMD_BYTE, random_alpha());
			repeat (n) send_beat(CMD_BYTE, random_word_char());
		end else if (pick < 58) begin
			repeat ($urandom_range(1, 6)) send_beat(CMD_BYTE, 8'("0" + $urandom_range(0, 9)));
		end else if (pick < 68) begin
			send_beat(CMD_BYTE, "\"");
			repeat ($urandom_range(0, 8)) begin
				if ($urandom_range(0, 7) == 0)
					b = "\n";
				else
					b = 8'($urandom_range(32, 126));
				if (b == "\"")
					b = "\\";
				send_beat(CMD_BYTE, b);
			end
			send_beat(CMD_BYTE, "\"");
		end else if (pick < 85) begin
			w = "(){}:,=+-*/";
			send_beat(CMD_BYTE, w[$urandom_range(0, 10)]);
		end else if (pick < 92) begin
			send_beat(CMD_BYTE, "\n");
		end else if (pick < 96) begin
			do
				b = 8'($urandom_range(0, 255));
			while (classify_byte(b) != CLS_OTHER);
			send_beat(CMD_BYTE, b);
		end else begin
			case ($urandom_range(0, 2))
				0: b = " ";
				1: b = "\t";
				default: b = 8'h0D;
			endcase
			send_beat(CMD_BYTE, b);
		end
		if ($urandom_range(0, 1) == 0)
			send_beat(CMD_BYTE, " ");
	endtask

	task automatic test_token_boundaries();
		send_text("ab1(");
		send_text("07x");
		send_beat(CMD_BYTE, 8'hFF);
		send_beat(CMD_BYTE, 8'h00);
		send_text("\t\n");
		send_text("\"\"");
		send_text("say");
		send_end();
	endtask

	task automatic test_unterminated_source();
		send_text("\"q\n");
		send_end();
		send_end();
	endtask

	task automatic test_random_sources();
		while (beats_sent < 1100) begin
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(3, 30)) send_random_lexeme();
			if ($urandom_range(0, 7) == 0) begin
				send_beat(CMD_BYTE, "\"");
				repeat ($urandom_range(0, 4)) send_beat(CMD_BYTE, random_word_char());
			end
			send_end();
		end
	endtask

	task automatic test_noise_bytes();
		steady = 1'b0;
		repeat (200) begin
			if ($urandom_range(0, 39) == 0)
				send_end();
			else
				send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
		end
		send_end();
	endtask

	task automatic check_field(input string name, input logic [23:0] exp_v,
			input logic [23:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// Reader side: random stalls between taken tokens.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			pop <= 1'b1;
			if (pop && !empty)
				stall_left <= pause_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			tokens_seen++;
			kind_tally[token_kind]++;
			if (expected_tokens.size() == 0) begin
				$display("%0t: token kind %0d at offset %0d arrived with none expected",
					$time, token_kind, start_offset);
				errors++;
			end else begin
				want = expected_tokens.pop_front();
				check_field("token_kind", 24'(want.kind), 24'(token_kind));
				check_field("keyword_index", 24'(want.kw), 24'(keyword_index));
				check_field("start_offset", want.start, start_offset);
				check_field("lexeme_length", want.len, lexeme_length);
				check_field("char_value", 24'(want.ch), 24'(char_value));
				check_field("token_line", want.line, token_line);
				check_field("last_of_run", 24'(want.last), 24'(last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		clear_lexer();
		foreach (kind_tally[i])
			kind_tally[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_token_boundaries();
		test_unterminated_source();
		test_random_sources();
		test_noise_bytes();
		push <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d beats over %0d sources and checked %0d tokens.",
			beats_sent, sources_ended, tokens_seen);
		$display("Keywords %0d, identifiers %0d, numbers %0d,",
			kind_tally[KIND_KEYWORD], kind_tally[KIND_IDENT], kind_tally[KIND_NUMBER]);
		$display("strings %0d, symbols %0d, errors %0d.",
			kind_tally[KIND_STRING], kind_tally[KIND_SYMBOL], kind_tally[KIND_ERROR]);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
